### rtl/core/ptpc_pkg.sv
// Shared types, constants and helpers for the pan/tilt position controller.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package ptpc_pkg;

  localparam int PRESET_SLOTS = 8;
  localparam int SLOT_W = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;

  localparam logic [7:0] MAX_PAN_RST     = 8'd172;
  localparam logic [7:0] MAX_TILT_RST    = 8'd40;
  localparam logic [7:0] CENTER_PAN_RST  = 8'd86;
  localparam logic [7:0] CENTER_TILT_RST = 8'd20;

  typedef enum logic [2:0] {
    CMD_LEFT  = 3'd0,
    CMD_RIGHT = 3'd1,
    CMD_UP    = 3'd2,
    CMD_DOWN  = 3'd3,
    CMD_STORE = 3'd4,
    CMD_GOTO  = 3'd5,
    CMD_CAL   = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MAX_PAN     = 2'd0,
    REG_MAX_TILT    = 2'd1,
    REG_CENTER_PAN  = 2'd2,
    REG_CENTER_TILT = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    CAL_HOME_PAN    = 2'd0,
    CAL_CENTER_PAN  = 2'd1,
    CAL_HOME_TILT   = 2'd2,
    CAL_CENTER_TILT = 2'd3
  } cal_phase_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] step_count;
    logic [3:0] preset_number;
  } cmd_item_t;

  typedef struct packed {
    logic       has_move;
    logic       axis;
    logic       direction;
    logic [7:0] move_steps;
    logic [7:0] pan_now;
    logic [7:0] tilt_now;
    logic       last;
  } res_item_t;

  typedef struct packed {
    logic [7:0] max_pan;
    logic [7:0] max_tilt;
    logic [7:0] center_pan;
    logic [7:0] center_tilt;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [15:0]       data;
  } wr_req_t;

  function automatic logic slot_ok(input logic [3:0] pn);
    logic [7:0] ext;
    ext = 8'(pn);
    return (pn != 4'd0) && (ext <= 8'(PRESET_SLOTS));
  endfunction

  function automatic logic [SLOT_W-1:0] slot_index(input logic [3:0] pn);
    logic [3:0] idx;
    idx = pn - 4'd1;
    return SLOT_W'(idx);
  endfunction

endpackage

`default_nettype wire

### rtl/core/ptpc_preset_ram.sv
// Preset store: one synchronous memory of pan/tilt pairs with a registered read.
// Per-entry valid bits stand in for the zero reset; a write in the read cycle is forwarded.
// Depends on ptpc_pkg.
`default_nettype none

module ptpc_preset_ram
  import ptpc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire rd_req_t rd,
  input  wire wr_req_t wr,
  output logic [15:0]  entry
);

  logic [15:0]             mem [PRESET_SLOTS];
  logic [PRESET_SLOTS-1:0] vld;
  logic [15:0]             rdata;
  logic                    rvld;
  logic                    fwd_hit;
  logic [15:0]             fwd_data;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      rvld    <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rvld    <= vld[rd.addr];
        fwd_hit <= wr.en && (wr.addr == rd.addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      fwd_data <= wr.data;
    end
  end

  assign entry = fwd_hit ? fwd_data : (rvld ? rdata : 16'd0);

endmodule

`default_nettype wire

### rtl/core/ptpc_exec.sv
// Command sequencer: holds one command, keeps the pan/tilt positions and emits one
// result per cycle unless take is low. Issues preset reads at acceptance and
// preset writes on store. Depends on ptpc_pkg.
`default_nettype none

module ptpc_exec
  import ptpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      cmd_valid,
  output logic           cmd_stall,
  input  wire cmd_item_t cmd_item,
  input  wire logic      take,
  output logic           fire,
  output res_item_t      result,
  output rd_req_t        rd,
  output wr_req_t        wr,
  input  wire logic [15:0] entry
);

  logic       busy;
  cmd_item_t  cur;
  logic [1:0] phase;
  logic [7:0] pan;
  logic [7:0] tilt;

  logic       accept;
  logic       ok;
  logic       has;
  logic       axis;
  logic       dir;
  logic [7:0] req;
  logic       last;
  logic [7:0] cur_pan;
  logic [7:0] cur_tilt;
  logic [7:0] pos;
  logic [7:0] lim;
  logic [7:0] room;
  logic [7:0] steps;
  logic [7:0] new_pos;
  logic [7:0] pan_next;
  logic [7:0] tilt_next;
  logic [7:0] tp;
  logic [7:0] tt;

  assign fire      = busy && take;
  assign cmd_stall = busy && !(fire && last);
  assign accept    = cmd_valid && !cmd_stall;
  assign ok        = slot_ok(cur.preset_number);
  assign tp        = entry[7:0];
  assign tt        = entry[15:8];

  assign rd.en   = accept && slot_ok(cmd_item.preset_number);
  assign rd.addr = slot_index(cmd_item.preset_number);

  assign wr.en   = fire && (cur.cmd == CMD_STORE) && ok;
  assign wr.addr = slot_index(cur.preset_number);
  assign wr.data = {tilt, pan};

  always_comb begin
    has      = 1'b0;
    axis     = 1'b0;
    dir      = 1'b0;
    req      = 8'd0;
    last     = 1'b1;
    cur_pan  = pan;
    cur_tilt = tilt;
    unique case (cur.cmd)
      CMD_LEFT: begin
        has = 1'b1; axis = 1'b0; dir = 1'b1; req = cur.step_count;
      end
      CMD_RIGHT: begin
        has = 1'b1; axis = 1'b0; dir = 1'b0; req = cur.step_count;
      end
      CMD_UP: begin
        has = 1'b1; axis = 1'b1; dir = 1'b1; req = cur.step_count;
      end
      CMD_DOWN: begin
        has = 1'b1; axis = 1'b1; dir = 1'b0; req = cur.step_count;
      end
      CMD_GOTO: begin
        // Pan goes first; the tilt leg follows in the next result when both differ.
        if (ok) begin
          if ((phase == 2'd0) && (tp != pan)) begin
            has  = 1'b1;
            axis = 1'b0;
            dir  = tp > pan;
            req  = dir ? (tp - pan) : (pan - tp);
            last = (tt == tilt);
          end else if (tt != tilt) begin
            has  = 1'b1;
            axis = 1'b1;
            dir  = tt > tilt;
            req  = dir ? (tt - tilt) : (tilt - tt);
          end
        end
      end
      CMD_CAL: begin
        has = 1'b1;
        unique case (phase)
          CAL_HOME_PAN: begin
            cur_pan  = cfg.max_pan;
            cur_tilt = cfg.max_tilt;
            axis = 1'b0; dir = 1'b0; req = cfg.max_pan; last = 1'b0;
          end
          CAL_CENTER_PAN: begin
            cur_pan = 8'd0;
            axis = 1'b0; dir = 1'b1; req = cfg.center_pan; last = 1'b0;
          end
          CAL_HOME_TILT: begin
            axis = 1'b1; dir = 1'b0; req = cfg.max_tilt; last = 1'b0;
          end
          CAL_CENTER_TILT: begin
            cur_tilt = 8'd0;
            axis = 1'b1; dir = 1'b1; req = cfg.center_tilt;
          end
          default: begin
            has = 1'b0;
          end
        endcase
      end
      default: begin
        has = 1'b0;
      end
    endcase

    pos  = axis ? cur_tilt : cur_pan;
    lim  = axis ? cfg.max_tilt : cfg.max_pan;
    room = (pos >= lim) ? 8'd0 : (lim - pos);
    if (!has) begin
      steps   = 8'd0;
      new_pos = pos;
    end else if (dir) begin
      steps   = (req > room) ? room : req;
      new_pos = pos + steps;
    end else begin
      steps   = (req > pos) ? pos : req;
      new_pos = pos - steps;
    end
    pan_next  = (has && !axis) ? new_pos : cur_pan;
    tilt_next = (has && axis) ? new_pos : cur_tilt;

    result.has_move   = has;
    result.axis       = has ? axis : 1'b0;
    result.direction  = has ? dir : 1'b0;
    result.move_steps = steps;
    result.pan_now    = pan_next;
    result.tilt_now   = tilt_next;
    result.last       = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 2'd0;
      pan   <= 8'd0;
      tilt  <= 8'd0;
    end else begin
      if (fire) begin
        pan  <= pan_next;
        tilt <= tilt_next;
        if (!last) begin
          phase <= phase + 2'd1;
        end
      end
      if (accept) begin
        busy  <= 1'b1;
        phase <= 2'd0;
      end else if (fire && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= cmd_item;
    end
  end

endmodule

`default_nettype wire

### rtl/core/pan_tilt_position_controller.sv
// Top level of the pan/tilt position controller: configuration registers, result
// register, command sequencer and preset memory. Depends on ptpc_pkg, ptpc_exec and
// ptpc_preset_ram.
//
//   channel   direction  handshake              payload
//   command   in         cmd_valid / cmd_stall  cmd_item (cmd_item_t)
//   result    out        res_valid / res_stall  res_item (res_item_t)
//   config    in         APB psel/penable/...   paddr[3:2] selects the register
//
// Each item causes one or more results: one for moves, store and unknown
// commands, one or two for goto, four for calibrate; the sequencer emits one result a
// cycle into the result register unless that register stalls. The first result of an
// item passes the sequencer's command register, then the result register, to the port.
// The preset memory read issues at acceptance; its registered data serves the item's results.
// Reset loads the limit defaults, zeroes both positions and marks all presets empty.
// A stalled result register holds the sequencer, which in turn stalls the command side.
`default_nettype none

module pan_tilt_position_controller
  import ptpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire cmd_item_t   cmd_item,
  output logic             res_valid,
  input  wire logic        res_stall,
  output res_item_t        res_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t        cfg;
  logic        take;
  logic        fire;
  res_item_t   result;
  rd_req_t     rd;
  wr_req_t     wr;
  logic [15:0] entry;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_pan     <= MAX_PAN_RST;
      cfg.max_tilt    <= MAX_TILT_RST;
      cfg.center_pan  <= CENTER_PAN_RST;
      cfg.center_tilt <= CENTER_TILT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_MAX_PAN:     cfg.max_pan     <= pwdata[7:0];
        REG_MAX_TILT:    cfg.max_tilt    <= pwdata[7:0];
        REG_CENTER_PAN:  cfg.center_pan  <= pwdata[7:0];
        REG_CENTER_TILT: cfg.center_tilt <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_PAN:     prdata = 32'(cfg.max_pan);
      REG_MAX_TILT:    prdata = 32'(cfg.max_tilt);
      REG_CENTER_PAN:  prdata = 32'(cfg.center_pan);
      REG_CENTER_TILT: prdata = 32'(cfg.center_tilt);
      default:         prdata = 32'd0;
    endcase
  end

  assign take = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (take && fire) begin
      res_item <= result;
    end
  end

  ptpc_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .take      (take),
    .fire      (fire),
    .result    (result),
    .rd        (rd),
    .wr        (wr),
    .entry     (entry)
  );

  ptpc_preset_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .rd    (rd),
    .wr    (wr),
    .entry (entry)
  );

endmodule

`default_nettype wire
